// ----- hw/rtl/mttp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttp_pkg
// Phase, role, record kind and error codes plus character helpers for the
// memory trace text parser.
// ----------------------------------------------------------------------------
package mttp_pkg;

  typedef logic [4:0] phase_t;
  typedef logic [3:0] role_t;
  typedef logic [1:0] arole_t;
  typedef logic [3:0] kind_t;
  typedef logic [2:0] err_t;

  localparam phase_t PH_START       = 5'd0;
  localparam phase_t PH_CHECK       = 5'd1;
  localparam phase_t PH_FINAL       = 5'd2;
  localparam phase_t PH_SYNC        = 5'd3;
  localparam phase_t PH_NUM         = 5'd4;
  localparam phase_t PH_SP_NUM      = 5'd5;
  localparam phase_t PH_SP_COLON    = 5'd6;
  localparam phase_t PH_AFTER_COLON = 5'd7;
  localparam phase_t PH_SP_ADDR     = 5'd8;
  localparam phase_t PH_BRACKET     = 5'd9;
  localparam phase_t PH_SP_CLOSE    = 5'd10;
  localparam phase_t PH_SP_OP       = 5'd11;
  localparam phase_t PH_EQ_TAIL     = 5'd12;
  localparam phase_t PH_SP_SEMI     = 5'd13;
  localparam phase_t PH_SP_BRACE    = 5'd14;
  localparam phase_t PH_AFTER_OP    = 5'd15;
  localparam phase_t PH_AFTER_TS    = 5'd16;
  localparam phase_t PH_TS_AT       = 5'd17;
  localparam phase_t PH_TS_COLON    = 5'd18;
  localparam phase_t PH_TS_GAP      = 5'd19;

  localparam role_t N_TID       = 4'd0;
  localparam role_t N_ADDR_V    = 4'd1;
  localparam role_t N_ADDR_M    = 4'd2;
  localparam role_t N_FIN_READ  = 4'd3;
  localparam role_t N_RMW_READ  = 4'd4;
  localparam role_t N_RMW_WRITE = 4'd5;
  localparam role_t N_LS_VAL    = 4'd6;
  localparam role_t N_TS_BEGIN  = 4'd7;
  localparam role_t N_TS_END    = 4'd8;

  localparam arole_t A_FIN  = 2'd0;
  localparam arole_t A_RMW1 = 2'd1;
  localparam arole_t A_RMW2 = 2'd2;
  localparam arole_t A_LS   = 2'd3;

  localparam kind_t KIND_LOAD      = 4'd0;
  localparam kind_t KIND_STORE     = 4'd1;
  localparam kind_t KIND_RMW       = 4'd2;
  localparam kind_t KIND_SYNC      = 4'd3;
  localparam kind_t KIND_FINAL     = 4'd4;
  localparam kind_t KIND_CHECK     = 4'd5;
  localparam kind_t KIND_DONE      = 4'd6;
  localparam kind_t KIND_DONE_DROP = 4'd7;
  localparam kind_t KIND_ERROR     = 4'd8;

  localparam err_t ERR_NONE     = 3'd0;
  localparam err_t ERR_BAD_CHAR = 3'd1;
  localparam err_t ERR_NUM_EXP  = 3'd2;
  localparam err_t ERR_NUM_LONG = 3'd3;
  localparam err_t ERR_RMW_ADDR = 3'd4;
  localparam err_t ERR_EOF      = 3'd5;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_M      = 8'h4d;

  function automatic logic is_blank(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c || b == 8'h0d;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Letters after the leading one of "check", "final" and "sync".
  function automatic logic [7:0] check_char(logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h68;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h6b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] final_char(logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h69;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h6c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sync_char(logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h79;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h63;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/mttp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttp_in_if
// Byte channel into the trace parser: valid/ready with text byte and end mark.
// ----------------------------------------------------------------------------
interface mttp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

// ----- hw/rtl/mttp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttp_out_if
// Record channel out of the trace parser: valid/ready with one parsed record.
// ----------------------------------------------------------------------------
interface mttp_out_if #(
  parameter int VALUE_WIDTH = 30,
  parameter int UID_WIDTH   = 20,
  parameter int LINE_WIDTH  = 24
);
  logic                       valid;
  logic                       ready;
  logic [3:0]                 kind;
  logic signed [UID_WIDTH:0]  op_uid;
  logic [VALUE_WIDTH-1:0]     thread_id;
  logic [VALUE_WIDTH-1:0]     mem_address;
  logic [VALUE_WIDTH-1:0]     read_value;
  logic [VALUE_WIDTH-1:0]     write_value;
  logic signed [VALUE_WIDTH:0] begin_time;
  logic signed [VALUE_WIDTH:0] end_time;
  logic [LINE_WIDTH-1:0]      line_number;
  logic [2:0]                 error_code;
  logic                       is_last;

  modport source (output valid, output kind, output op_uid, output thread_id,
                  output mem_address, output read_value, output write_value,
                  output begin_time, output end_time, output line_number,
                  output error_code, output is_last, input ready);
  modport sink   (input valid, input kind, input op_uid, input thread_id,
                  input mem_address, input read_value, input write_value,
                  input begin_time, input end_time, input line_number,
                  input error_code, input is_last, output ready);
endinterface

// ----- hw/rtl/memory_trace_text_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_trace_text_parser
// Parses a memory trace text one byte per transfer into operation records.
// Records of a byte are written into the registered result queue at its transfer.
// Throughput: one byte per cycle; a byte yields at most two records, which a
// four-entry result queue holds, so input stalls only while three or more wait.
// Reset (synchronous, active low) returns the parser to line one, clears the
// queue and the halted flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module memory_trace_text_parser #(
  parameter int MAX_DIGITS  = 9,
  parameter int VALUE_WIDTH = 30,
  parameter int UID_WIDTH   = 20,
  parameter int LINE_WIDTH  = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  mttp_in_if.sink    in_ch,
  mttp_out_if.source out_ch
);
  import mttp_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int UW = UID_WIDTH;
  localparam int LW = LINE_WIDTH;
  localparam int DW = $clog2(MAX_DIGITS + 1);

  typedef struct packed {
    kind_t                kind;
    logic signed [UW:0]   uid;
    logic [VW-1:0]        thr;
    logic [VW-1:0]        adr;
    logic [VW-1:0]        rd;
    logic [VW-1:0]        wr;
    logic signed [VW:0]   tb;
    logic signed [VW:0]   te;
    logic [LW-1:0]        line;
    err_t                 err;
    logic                 last;
  } rec_t;

  typedef struct packed {
    phase_t             phase;
    logic [DW-1:0]      dcnt;
    logic [VW-1:0]      acc;
    logic               zeroed;
    logic [2:0]         lit;
    role_t              nrole;
    arole_t             arole;
    logic [2:0]         pkind;
    logic               pvalid;
    logic [VW-1:0]      pthr;
    logic [VW-1:0]      padr;
    logic [VW-1:0]      prd;
    logic [VW-1:0]      pwr;
    logic signed [VW:0] pbeg;
    logic signed [VW:0] pend;
    logic [UW-1:0]      uid;
    logic [LW-1:0]      sline;
    logic               incomm;
    logic               chk;
    logic               halted;
  } st_t;

  typedef struct packed {
    st_t        s;
    logic       again;
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } wk_t;

  function automatic rec_t mk_rec(kind_t k, logic signed [UW:0] uid, logic [VW-1:0] thr,
                                  logic [VW-1:0] adr, logic [VW-1:0] rd, logic [VW-1:0] wr,
                                  logic signed [VW:0] tb, logic signed [VW:0] te,
                                  logic [LW-1:0] line, err_t err);
    rec_t r;
    r.kind = k; r.uid = uid; r.thr = thr; r.adr = adr; r.rd = rd; r.wr = wr;
    r.tb = tb; r.te = te; r.line = line; r.err = err; r.last = 1'b0;
    return r;
  endfunction

  function automatic rec_t mk_plain(kind_t k, logic [LW-1:0] line, err_t err);
    return mk_rec(k, '1, '0, '0, '0, '0, '1, '1, line, err);
  endfunction

  function automatic wk_t push_rec(wk_t w_in, rec_t r);
    wk_t w;
    w = w_in;
    if (w.n == 2'd0) begin
      w.r0 = r;
    end else if (w.n == 2'd1) begin
      w.r1 = r;
    end
    if (w.n != 2'd2) w.n = w.n + 2'd1;
    return w;
  endfunction

  function automatic wk_t fail(wk_t w_in, err_t code, logic [LW-1:0] line);
    wk_t w;
    w = push_rec(w_in, mk_plain(KIND_ERROR, line, code));
    w.s.halted = 1'b1;
    return w;
  endfunction

  function automatic wk_t emit_pending(wk_t w_in);
    wk_t w;
    w = w_in;
    if (w.s.pvalid) begin
      w = push_rec(w, mk_rec({1'b0, w.s.pkind}, {1'b0, w.s.uid}, w.s.pthr, w.s.padr,
                             w.s.prd, w.s.pwr, w.s.pbeg, w.s.pend, w.s.sline, ERR_NONE));
      w.s.uid    = w.s.uid + 1'b1;
      w.s.pvalid = 1'b0;
    end
    return w;
  endfunction

  function automatic wk_t start_num(wk_t w_in, role_t role, phase_t ph);
    wk_t w;
    w = w_in;
    w.s.nrole  = role;
    w.s.acc    = '0;
    w.s.zeroed = 1'b1;
    w.s.dcnt   = '0;
    w.s.phase  = ph;
    return w;
  endfunction

  function automatic wk_t addr_done(wk_t w_in, logic [LW-1:0] line);
    wk_t w;
    w = w_in;
    if (w.s.arole == A_RMW2) begin
      if (w.s.acc != w.s.padr) w = fail(w, ERR_RMW_ADDR, line);
      else w.s.phase = PH_SP_OP;
    end else begin
      w.s.padr  = w.s.acc;
      w.s.phase = PH_SP_OP;
    end
    return w;
  endfunction

  function automatic wk_t finish_num(wk_t w_in, logic [LW-1:0] line);
    wk_t w;
    logic [VW-1:0] v;
    w = w_in;
    v = w.s.acc;
    unique case (w.s.nrole)
      N_TID: begin
        w.s.pthr  = v;
        w.s.phase = PH_SP_COLON;
      end
      N_ADDR_V:   w = addr_done(w, line);
      N_ADDR_M:   w.s.phase = PH_SP_CLOSE;
      N_FIN_READ: begin
        w = push_rec(w, mk_rec(KIND_FINAL, '1, '0, w.s.padr, v, '0, '1, '1,
                               w.s.sline, ERR_NONE));
        w.s.phase = PH_START;
      end
      N_RMW_READ: begin
        w.s.prd   = v;
        w.s.phase = PH_SP_SEMI;
      end
      N_RMW_WRITE: begin
        w.s.pwr   = v;
        w.s.phase = PH_SP_BRACE;
      end
      N_LS_VAL: begin
        if (w.s.pkind == KIND_LOAD[2:0]) w.s.prd = v;
        else w.s.pwr = v;
        w.s.pvalid = 1'b1;
        w.s.phase  = PH_AFTER_OP;
      end
      N_TS_BEGIN: begin
        w.s.pbeg  = $signed({1'b0, v});
        w.s.phase = PH_TS_COLON;
      end
      default: begin
        w.s.pend  = $signed({1'b0, v});
        w.s.phase = PH_AFTER_TS;
      end
    endcase
    return w;
  endfunction

  // One pass of the byte through the current phase; again asks for another.
  function automatic wk_t handle(wk_t w_in, logic [7:0] b, logic [LW-1:0] line,
                                 logic [VW-1:0] acc10);
    wk_t  w;
    logic sk;
    w  = w_in;
    sk = is_blank(b) || (b == CH_HASH);
    unique case (w.s.phase)
      PH_START: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else begin
          w.s.sline = line;
          w.s.pthr  = '0;
          w.s.padr  = '0;
          w.s.prd   = '0;
          w.s.pwr   = '0;
          w.s.pbeg  = '1;
          w.s.pend  = '1;
          if (b == CH_C) begin
            w.s.lit   = '0;
            w.s.phase = PH_CHECK;
          end else if (b == CH_F) begin
            w.s.lit   = '0;
            w.s.phase = PH_FINAL;
          end else begin
            w       = start_num(w, N_TID, PH_NUM);
            w.again = 1'b1;
          end
        end
      end
      PH_CHECK: begin
        if (w.s.lit > 3'd3 || b != check_char(w.s.lit)) begin
          w = fail(w, ERR_BAD_CHAR, line);
        end else begin
          w.s.lit = w.s.lit + 3'd1;
          if (w.s.lit == 3'd4) begin
            w = push_rec(w, mk_plain(KIND_CHECK, w.s.sline, ERR_NONE));
            w.s.uid   = '0;
            w.s.chk   = 1'b1;
            w.s.phase = PH_START;
          end
        end
      end
      PH_FINAL: begin
        if (w.s.lit > 3'd3 || b != final_char(w.s.lit)) begin
          w = fail(w, ERR_BAD_CHAR, line);
        end else begin
          w.s.lit = w.s.lit + 3'd1;
          if (w.s.lit == 3'd4) begin
            w.s.arole = A_FIN;
            w.s.phase = PH_SP_ADDR;
          end
        end
      end
      PH_SYNC: begin
        if (w.s.lit > 3'd2 || b != sync_char(w.s.lit)) begin
          w = fail(w, ERR_BAD_CHAR, line);
        end else begin
          w.s.lit = w.s.lit + 3'd1;
          if (w.s.lit == 3'd3) begin
            w.s.pkind  = KIND_SYNC[2:0];
            w.s.pvalid = 1'b1;
            w.s.phase  = PH_AFTER_OP;
          end
        end
      end
      PH_NUM: begin
        if (is_digit(b)) begin
          if (w.s.dcnt >= DW'(MAX_DIGITS)) begin
            w = fail(w, ERR_NUM_LONG, line);
          end else begin
            w.s.acc    = w.s.zeroed ? {{(VW-4){1'b0}}, b[3:0]} : acc10;
            w.s.zeroed = 1'b0;
            w.s.dcnt   = w.s.dcnt + 1'b1;
          end
        end else if (w.s.dcnt == '0) begin
          w = fail(w, ERR_NUM_EXP, line);
        end else begin
          w       = finish_num(w, line);
          w.again = 1'b1;
        end
      end
      PH_SP_NUM: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else begin
          w.s.phase = PH_NUM;
          w.again   = 1'b1;
        end
      end
      PH_SP_COLON: begin
        if (sk) w.s.incomm = (b == CH_HASH);
        else if (b == CH_COLON) w.s.phase = PH_AFTER_COLON;
        else w = fail(w, ERR_BAD_CHAR, line);
      end
      PH_AFTER_COLON: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else if (b == CH_LBRACE) begin
          w.s.pkind = KIND_RMW[2:0];
          w.s.arole = A_RMW1;
          w.s.phase = PH_SP_ADDR;
        end else if (b == CH_S) begin
          w.s.lit   = '0;
          w.s.phase = PH_SYNC;
        end else begin
          w.s.arole = A_LS;
          w.s.phase = PH_SP_ADDR;
          w.again   = 1'b1;
        end
      end
      PH_SP_ADDR: begin
        if (sk) w.s.incomm = (b == CH_HASH);
        else if (b == CH_M) w.s.phase = PH_BRACKET;
        else if (b == CH_V) w = start_num(w, N_ADDR_V, PH_NUM);
        else w = fail(w, ERR_BAD_CHAR, line);
      end
      PH_BRACKET: begin
        if (b == CH_LBRACK) w = start_num(w, N_ADDR_M, PH_SP_NUM);
        else w = fail(w, ERR_BAD_CHAR, line);
      end
      PH_SP_CLOSE: begin
        if (sk) w.s.incomm = (b == CH_HASH);
        else if (b == CH_RBRACK) w = addr_done(w, line);
        else w = fail(w, ERR_BAD_CHAR, line);
      end
      PH_SP_OP: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else if (w.s.arole == A_LS && (b == CH_EQ || b == CH_COLON)) begin
          w.s.pkind = (b == CH_EQ) ? KIND_LOAD[2:0] : KIND_STORE[2:0];
          w.s.nrole = N_LS_VAL;
          w.s.phase = PH_EQ_TAIL;
        end else if ((w.s.arole == A_FIN || w.s.arole == A_RMW1) && b == CH_EQ) begin
          w.s.nrole = (w.s.arole == A_FIN) ? N_FIN_READ : N_RMW_READ;
          w.s.phase = PH_EQ_TAIL;
        end else if (w.s.arole == A_RMW2 && b == CH_COLON) begin
          w.s.nrole = N_RMW_WRITE;
          w.s.phase = PH_EQ_TAIL;
        end else begin
          w = fail(w, ERR_BAD_CHAR, line);
        end
      end
      PH_EQ_TAIL: begin
        if (b == CH_EQ) w = start_num(w, w.s.nrole, PH_SP_NUM);
        else w = fail(w, ERR_BAD_CHAR, line);
      end
      PH_SP_SEMI: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else if (b == CH_SEMI) begin
          w.s.arole = A_RMW2;
          w.s.phase = PH_SP_ADDR;
        end else begin
          w = fail(w, ERR_BAD_CHAR, line);
        end
      end
      PH_SP_BRACE: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else if (b == CH_RBRACE) begin
          w.s.pvalid = 1'b1;
          w.s.phase  = PH_AFTER_OP;
        end else begin
          w = fail(w, ERR_BAD_CHAR, line);
        end
      end
      PH_AFTER_OP: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else if (b == CH_AT) begin
          w.s.phase = PH_TS_AT;
        end else begin
          w         = emit_pending(w);
          w.s.phase = PH_START;
          w.again   = 1'b1;
        end
      end
      PH_AFTER_TS: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else begin
          w         = emit_pending(w);
          w.s.phase = PH_START;
          w.again   = 1'b1;
        end
      end
      PH_TS_AT: begin
        if (sk) begin
          w.s.incomm = (b == CH_HASH);
        end else if (b == CH_COLON) begin
          w.s.phase = PH_TS_GAP;
        end else begin
          w       = start_num(w, N_TS_BEGIN, PH_NUM);
          w.again = 1'b1;
        end
      end
      PH_TS_COLON: begin
        if (b == CH_COLON) w.s.phase = PH_TS_GAP;
        else w = fail(w, ERR_BAD_CHAR, line);
      end
      PH_TS_GAP: begin
        if (is_digit(b)) w = start_num(w, N_TS_END, PH_NUM);
        else w.s.phase = PH_AFTER_TS;
        w.again = 1'b1;
      end
      default: w = fail(w, ERR_BAD_CHAR, line);
    endcase
    return w;
  endfunction

  st_t            st_r, st_nxt;
  logic [LW-1:0]  line_r, line_nxt;
  wk_t            wk;
  logic [VW+2:0]  acc10_full;
  logic [VW-1:0]  acc10;
  logic           in_xfer;
  logic           out_xfer;

  rec_t           q_r [4];
  logic [1:0]     wptr_r, rptr_r;
  logic [2:0]     qcnt_r, qcnt_nxt;
  logic [2:0]     push_n;

  assign acc10_full = {st_r.acc, 3'b000} + {2'b00, st_r.acc, 1'b0}
                      + {{(VW-1){1'b0}}, in_ch.text_byte[3:0]};
  assign acc10      = acc10_full[VW-1:0];

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  always_comb begin
    wk   = '0;
    wk.s = st_r;
    if (!st_r.halted) begin
      if (in_ch.end_of_input) begin
        if (st_r.phase == PH_START || st_r.phase == PH_AFTER_OP ||
            st_r.phase == PH_AFTER_TS) begin
          wk = emit_pending(wk);
          wk = push_rec(wk, mk_plain(st_r.chk ? KIND_DONE_DROP : KIND_DONE, line_r,
                                     ERR_NONE));
          wk.s.halted = 1'b1;
        end else begin
          wk = fail(wk, ERR_EOF, line_r);
        end
      end else if (st_r.incomm) begin
        if (in_ch.text_byte == CH_LF) wk.s.incomm = 1'b0;
      end else begin
        wk.again = 1'b1;
        // Chains of re-handling run at most four passes deep.
        for (int i = 0; i < 4; i++) begin
          if (wk.again && !wk.s.halted) begin
            wk.again = 1'b0;
            wk       = handle(wk, in_ch.text_byte, line_r, acc10);
          end
        end
      end
    end
    if (wk.n == 2'd1) wk.r0.last = 1'b1;
    if (wk.n == 2'd2) wk.r1.last = 1'b1;
    st_nxt = wk.s;
  end

  always_comb begin
    line_nxt = line_r;
    if (!st_r.halted && !in_ch.end_of_input && in_ch.text_byte == CH_LF &&
        line_r != '1) begin
      line_nxt = line_r + 1'b1;
    end
  end

  assign push_n   = in_xfer ? {1'b0, wk.n} : 3'd0;
  assign qcnt_nxt = qcnt_r + push_n - {2'b00, out_xfer};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      st_r.phase  <= PH_START;
      st_r.pbeg   <= '1;
      st_r.pend   <= '1;
      st_r.sline  <= LW'(1);
      line_r      <= LW'(1);
      wptr_r      <= '0;
      rptr_r      <= '0;
      qcnt_r      <= '0;
    end else begin
      if (in_xfer) begin
        st_r   <= st_nxt;
        line_r <= line_nxt;
        wptr_r <= wptr_r + wk.n;
      end
      if (out_xfer) rptr_r <= rptr_r + 2'd1;
      qcnt_r <= qcnt_nxt;
    end
  end

  // Queue entries hold payload only; no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer && wk.n != 2'd0) q_r[wptr_r] <= wk.r0;
    if (in_xfer && wk.n == 2'd2) q_r[wptr_r + 2'd1] <= wk.r1;
  end

  assign in_ch.ready        = (qcnt_r <= 3'd2);
  assign out_ch.valid       = (qcnt_r != 3'd0);
  assign out_ch.kind        = q_r[rptr_r].kind;
  assign out_ch.op_uid      = q_r[rptr_r].uid;
  assign out_ch.thread_id   = q_r[rptr_r].thr;
  assign out_ch.mem_address = q_r[rptr_r].adr;
  assign out_ch.read_value  = q_r[rptr_r].rd;
  assign out_ch.write_value = q_r[rptr_r].wr;
  assign out_ch.begin_time  = q_r[rptr_r].tb;
  assign out_ch.end_time    = q_r[rptr_r].te;
  assign out_ch.line_number = q_r[rptr_r].line;
  assign out_ch.error_code  = q_r[rptr_r].err;
  assign out_ch.is_last     = q_r[rptr_r].last;

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 3'd4) else $error("result queue overflow");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && st_r.halted) |=> (qcnt_r <= $past(qcnt_r)))
    else $error("records pushed after halt");

  a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.end_of_input) |=> st_r.halted)
    else $error("end of input did not halt parser");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dcnt <= DW'(MAX_DIGITS)) else $error("digit count past limit");

endmodule
